### rtl/mse_pkg.sv
// shared opcodes, function codes and types of the mips subset execute core
package mse_pkg;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE     = 6'd0;
  localparam logic [5:0] OP_J         = 6'd2;
  localparam logic [5:0] OP_JAL       = 6'd3;
  localparam logic [5:0] OP_BEQ       = 6'd4;
  localparam logic [5:0] OP_BNE       = 6'd5;
  localparam logic [5:0] OP_BLEZ      = 6'd6;
  localparam logic [5:0] OP_ADD_IMM   = 6'd9;
  localparam logic [5:0] OP_SLTI      = 6'd10;
  localparam logic [5:0] OP_SLT_IMM_U = 6'd11;
  localparam logic [5:0] OP_ORI       = 6'd13;
  localparam logic [5:0] OP_LUI       = 6'd15;
  localparam logic [5:0] OP_LB        = 6'd32;
  localparam logic [5:0] OP_LW        = 6'd35;
  localparam logic [5:0] OP_LBU       = 6'd36;
  localparam logic [5:0] OP_SB        = 6'd40;
  localparam logic [5:0] OP_SW        = 6'd43;

  // special function codes
  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_JALR = 6'd9;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;

  localparam logic [31:0] JUMP_REGION = 32'hf0000000;
  localparam logic [31:0] BYTE_MASK   = 32'h000000ff;
  localparam logic [4:0]  LINK_REG    = 5'd31;

  // item kinds
  localparam logic FUNC_EXEC    = 1'b0;
  localparam logic FUNC_PRELOAD = 1'b1;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_LW,
    MOP_LB,
    MOP_LBU,
    MOP_SW,
    MOP_SB,
    MOP_PRELOAD
  } mem_op_t;

  // execute stage result handed to the memory stage
  typedef struct packed {
    logic [31:0] next_pc;
    logic        fault;
    logic        jump;
    logic [31:0] target;
    logic        wr;
    logic [4:0]  wi;
    logic [31:0] wv;
    mem_op_t     mop;
    logic [31:0] addr;
    logic [31:0] st_data;
  } ex_t;

endpackage

### rtl/mse_exec.sv
// decode and execute of one instruction or preload item
module mse_exec import mse_pkg::*; (
  input  logic        func,
  input  logic [31:0] instr,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] pc,
  input  logic        delay_pending,
  input  logic [31:0] delay_target,
  input  logic        halted,
  input  logic [31:0] pload_addr,
  input  logic [31:0] pload_data,
  output ex_t         ex
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [31:0] simm;
  logic [31:0] seq;

  assign op   = instr[31:26];
  assign rt   = instr[20:16];
  assign rd   = instr[15:11];
  assign sa   = instr[10:6];
  assign fn   = instr[5:0];
  assign simm = {{16{instr[15]}}, instr[15:0]};
  assign seq  = pc + 32'd4;

  always_comb begin
    ex         = '0;
    ex.mop     = MOP_NONE;
    ex.next_pc = delay_pending ? delay_target : seq;
    if (func == FUNC_PRELOAD) begin
      ex.next_pc = pc;
      ex.mop     = MOP_PRELOAD;
      ex.addr    = pload_addr;
      ex.st_data = pload_data;
    end else begin
      unique case (op)
        OP_RTYPE: begin
          ex.wi = rd;
          ex.wr = 1'b1;
          unique case (fn)
            FN_SLL:  ex.wv = b << sa;
            FN_SRL:  ex.wv = b >> sa;
            FN_SRA:  ex.wv = 32'($signed(b) >>> sa);
            FN_JR: begin
              ex.wr     = 1'b0;
              ex.jump   = 1'b1;
              ex.target = a;
            end
            FN_JALR: begin
              ex.wv     = pc + 32'd8;
              ex.jump   = 1'b1;
              ex.target = a;
            end
            FN_ADD, FN_ADDU: ex.wv = a + b;
            FN_SUB:  ex.wv = a - b;
            FN_AND:  ex.wv = a & b;
            FN_OR:   ex.wv = a | b;
            FN_XOR:  ex.wv = a ^ b;
            FN_NOR:  ex.wv = ~(a | b);
            FN_SLT:  ex.wv = {31'd0, $signed(a) < $signed(b)};
            default: begin
              ex.wr    = 1'b0;
              ex.fault = 1'b1;
            end
          endcase
        end
        OP_J, OP_JAL: begin
          ex.jump   = 1'b1;
          ex.target = (seq & JUMP_REGION) | {4'd0, instr[25:0], 2'b00};
          if (op == OP_JAL) begin
            ex.wr = 1'b1;
            ex.wi = LINK_REG;
            ex.wv = pc + 32'd8;
          end
        end
        OP_BEQ, OP_BNE, OP_BLEZ: begin
          priority if (op == OP_BEQ) ex.jump = (a == b);
          else if (op == OP_BNE)     ex.jump = (a != b);
          else                       ex.jump = (a == 32'd0) || a[31];
          ex.target = seq + {simm[29:0], 2'b00};
        end
        OP_ADD_IMM: begin ex.wr = 1'b1; ex.wi = rt; ex.wv = a + simm; end
        OP_SLTI: begin
          ex.wr = 1'b1;
          ex.wi = rt;
          ex.wv = {31'd0, $signed(a) < $signed(simm)};
        end
        OP_SLT_IMM_U: begin ex.wr = 1'b1; ex.wi = rt; ex.wv = {31'd0, a < simm}; end
        OP_ORI: begin ex.wr = 1'b1; ex.wi = rt; ex.wv = a | {16'd0, instr[15:0]}; end
        OP_LUI: begin ex.wr = 1'b1; ex.wi = rt; ex.wv = {instr[15:0], 16'd0}; end
        OP_LB, OP_LW, OP_LBU, OP_SB, OP_SW: begin
          ex.addr    = a + simm;
          ex.st_data = b;
          unique case (op)
            OP_LW:   begin ex.mop = MOP_LW;  ex.wr = 1'b1; ex.wi = rt; end
            OP_LB:   begin ex.mop = MOP_LB;  ex.wr = 1'b1; ex.wi = rt; end
            OP_LBU:  begin ex.mop = MOP_LBU; ex.wr = 1'b1; ex.wi = rt; end
            OP_SW:   ex.mop = MOP_SW;
            default: ex.mop = MOP_SB;
          endcase
        end
        default: ex.fault = 1'b1;
      endcase
      // a halted core answers every instruction with a fault
      if (halted) ex.fault = 1'b1;
      if (ex.fault) begin
        ex         = '0;
        ex.mop     = MOP_NONE;
        ex.fault   = 1'b1;
        ex.next_pc = pc;
      end
      // register zero is never written
      if (!ex.wr || ex.wi == 5'd0) begin
        ex.wr = 1'b0;
        ex.wi = 5'd0;
        ex.wv = 32'd0;
      end
    end
  end

endmodule

### rtl/mips_subset_execute_core.sv
// mips integer subset executor: register file, data memory, pc and delay slot
// an accepted item passes the stage 1, stage 2 and output registers on its way to m_tvalid
// throughput: one item per cycle while m_tready does not stall and no clear runs
// register file and data memory reads are registered, with forwarding
// reset: synchronous; afterwards a clearing pass zeroes the data memory,
// one word a cycle over all DMEM_WORDS words, during which no item is taken
module mips_subset_execute_core import mse_pkg::*; #(
  parameter int DMEM_WORDS = 1024  // power of two
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // instr, preload_index, preload_data, zero pad
  input  logic         s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // next_pc, reg_write, reg_index, reg_value,
                                  // mem_write, mem_addr, mem_data, fault
);

  localparam int AW = $clog2(DMEM_WORDS);

  logic        adv;
  logic        accept;
  logic        clr_busy;
  logic [AW-1:0] clr_cnt;

  // register file and its valid bits
  logic [31:0] rf [32];
  logic [31:0] rf_valid;
  logic [31:0] qa, qb;
  logic        va1, vb1;
  logic        rf_we;

  // data memory
  logic [31:0]   dmem [DMEM_WORDS];
  logic [31:0]   dq;
  logic          dm_we;
  logic [AW-1:0] dm_wa;
  logic [31:0]   dm_wd;

  // architectural state
  logic [31:0] pc;
  logic        dpend;
  logic [31:0] dtarget;
  logic        halted;

  // stage 1
  logic        v1;
  logic        func1;
  logic [31:0] instr1;
  logic [9:0]  pidx1;
  logic [31:0] pdata1;
  logic        pw_v;
  logic [4:0]  pw_i;
  logic [31:0] pw_val;
  logic [31:0] a1, b1;
  logic [31:0] pidx_ext;
  logic [31:0] pload_addr;
  logic [AW-1:0] idx1;
  ex_t         ex1;

  // stage 2
  logic          v2;
  ex_t           ex2;
  logic [AW-1:0] idx2;
  logic          hit2;
  logic [31:0]   fdata2;
  logic [31:0]   word2;
  logic [4:0]    sh2;
  logic [7:0]    byte2;
  logic [31:0]   wv2f;
  logic [31:0]   mdata2f;
  logic          dm_wr2;

  // global advance: the whole pipe moves when the output register can load
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !clr_busy;
  assign accept   = s_tvalid && s_tready;

  // clearing pass over the data memory
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(DMEM_WORDS - 1)) clr_busy <= 1'b0;
    end
  end

  // register file reads at accept, write from stage 2
  always_ff @(posedge clk) begin
    if (adv) begin
      qa  <= rf[s_tdata[25:21]];
      qb  <= rf[s_tdata[20:16]];
      va1 <= rf_valid[s_tdata[25:21]];
      vb1 <= rf_valid[s_tdata[20:16]];
    end
    if (rf_we) rf[ex2.wi] <= wv2f;
  end

  always_ff @(posedge clk) begin
    if (rst) rf_valid <= '0;
    else if (rf_we) rf_valid[ex2.wi] <= 1'b1;
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      pw_v <= 1'b0;
    end else if (adv) begin
      v1   <= accept;
      pw_v <= rf_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1  <= s_tuser;
      instr1 <= s_tdata[31:0];
      pidx1  <= s_tdata[41:32];
      pdata1 <= s_tdata[73:42];
      pw_i   <= ex2.wi;
      pw_val <= wv2f;
    end
  end

  // operand forwarding: stage 2 write, then the write seen at read time
  always_comb begin
    priority if (v2 && ex2.wr && ex2.wi == instr1[25:21]) a1 = wv2f;
    else if (pw_v && pw_i == instr1[25:21])               a1 = pw_val;
    else                                                   a1 = va1 ? qa : 32'd0;
    priority if (v2 && ex2.wr && ex2.wi == instr1[20:16]) b1 = wv2f;
    else if (pw_v && pw_i == instr1[20:16])               b1 = pw_val;
    else                                                   b1 = vb1 ? qb : 32'd0;
  end

  assign pidx_ext   = {22'd0, pidx1};
  assign pload_addr = 32'(pidx_ext[AW-1:0]) << 2;

  mse_exec u_exec (
    .func          (func1),
    .instr         (instr1),
    .a             (a1),
    .b             (b1),
    .pc            (pc),
    .delay_pending (dpend),
    .delay_target  (dtarget),
    .halted        (halted),
    .pload_addr    (pload_addr),
    .pload_data    (pdata1),
    .ex            (ex1)
  );

  assign idx1 = ex1.addr[AW+1:2];

  // pc, delay slot and halt update in program order
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      dpend  <= 1'b0;
      halted <= 1'b0;
    end else if (adv && v1 && func1 == FUNC_EXEC) begin
      if (ex1.fault) begin
        halted <= 1'b1;
      end else begin
        pc    <= ex1.next_pc;
        dpend <= ex1.jump;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1 && func1 == FUNC_EXEC && !ex1.fault && ex1.jump) dtarget <= ex1.target;
  end

  // data memory read for stage 2, with same-word forwarding
  always_ff @(posedge clk) begin
    if (adv) dq <= dmem[idx1];
    if (dm_we) dmem[dm_wa] <= dm_wd;
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex2    <= ex1;
      idx2   <= idx1;
      hit2   <= v2 && dm_wr2 && idx2 == idx1;
      fdata2 <= mdata2f;
    end
  end

  // load extraction and byte merge
  assign word2  = hit2 ? fdata2 : dq;
  assign sh2    = {ex2.addr[1:0], 3'b000};
  assign byte2  = 8'(word2 >> sh2);
  assign dm_wr2 = ex2.mop == MOP_SW || ex2.mop == MOP_SB || ex2.mop == MOP_PRELOAD;

  always_comb begin
    unique case (ex2.mop)
      MOP_LW:  wv2f = word2;
      MOP_LB:  wv2f = {{24{byte2[7]}}, byte2};
      MOP_LBU: wv2f = {24'd0, byte2};
      default: wv2f = ex2.wv;
    endcase
    unique case (ex2.mop)
      MOP_SW, MOP_PRELOAD: mdata2f = ex2.st_data;
      MOP_SB: mdata2f = (word2 & ~(BYTE_MASK << sh2)) | ((ex2.st_data & BYTE_MASK) << sh2);
      default: mdata2f = 32'd0;
    endcase
  end

  assign rf_we = adv && v2 && ex2.wr;
  assign dm_we = clr_busy || (adv && v2 && dm_wr2);
  assign dm_wa = clr_busy ? clr_cnt : idx2;
  assign dm_wd = clr_busy ? 32'd0 : mdata2f;

  // output register; a load into register zero reports no value
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) m_tdata <= {ex2.fault, mdata2f, ex2.addr, dm_wr2,
                         (ex2.wr ? wv2f : 32'd0), ex2.wi, ex2.wr, ex2.next_pc};
  end

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halted cleared without reset");

  // a faulting item writes nothing
  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[135] |-> !m_tdata[32] && !m_tdata[70])
    else $error("fault item with a write");

  // register zero never written
  a_no_r0: assert property (@(posedge clk) disable iff (rst) rf_we |-> ex2.wi != 5'd0)
    else $error("write to register zero");

  // no item enters while the memory is being cleared
  a_clr_block: assert property (@(posedge clk) disable iff (rst) clr_busy |=> !v1)
    else $error("item taken during clearing pass");

endmodule
